FILE: hdl/vtu_pkg.sv
// ----------------------------------------------------------------------------
// vtu_pkg
// Shared types, constants and command codes of the Verlet translation update.
// ----------------------------------------------------------------------------
`default_nettype none
package vtu_pkg;

    localparam int PARTICLE_COUNT_DEF = 1024;
    localparam int AXES               = 3;
    localparam int CFG_W              = 17;
    localparam int WORD_W             = 32;
    localparam int PIDX_W             = 10;

    localparam logic [CFG_W-1:0] TIME_STEP_RST       = 17'd66;
    localparam logic [CFG_W-1:0] FORCE_REDUCTION_RST = 17'd65536;

    typedef enum logic [1:0] {
        CMD_PREDICT   = 2'd0,
        CMD_CORRECT   = 2'd1,
        CMD_LOAD_POS  = 2'd2,
        CMD_LOAD_VEL  = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        REG_TIME_STEP       = 1'b0,
        REG_FORCE_REDUCTION = 1'b1
    } reg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;   // write zero to all stores at clear address
        logic start;      // latch input item, begin axis work
        logic div_start;  // start divider for current axis
        logic rd;         // issue store reads for current axis
        logic calc;       // capture products
        logic wb;         // write back axis, record result word
        logic load;       // load command writes
        logic out_load;   // move result into output register
        logic [1:0] axis;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic is_load;
        logic in_range;
    } sts_t;

    function automatic logic [WORD_W-1:0] sat32(input logic signed [WORD_W+1:0] v);
        logic [WORD_W-1:0] r;
        if (v > $signed({3'b000, {(WORD_W-1){1'b1}}}))
            r = {1'b0, {(WORD_W-1){1'b1}}};
        else if (v < $signed({3'b111, {(WORD_W-1){1'b0}}}))
            r = {1'b1, {(WORD_W-1){1'b0}}};
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/vtu_ram.sv
// ----------------------------------------------------------------------------
// vtu_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module vtu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3072
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/vtu_div.sv
// ----------------------------------------------------------------------------
// vtu_div
// Restoring divider, one quotient bit per cycle: floor(num / den) and remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module vtu_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quot,
    output logic      [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   shifted;

    always_comb
    begin
        shifted = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        trial   = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[DEN_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/vtu_ctrl.sv
// ----------------------------------------------------------------------------
// vtu_ctrl
// Sequencer: clearing pass, then per predict or correct item three axes of
// read, divide, compute and write back, then result transfer (not for loads).
// ----------------------------------------------------------------------------
`default_nettype none
module vtu_ctrl #(
    parameter int DEPTH = 3072
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic                     out_free,
    input  vtu_pkg::sts_t                 sts,
    output vtu_pkg::ctl_t                 ctl,
    output logic      [$clog2(DEPTH)-1:0] clr_addr
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DEC   = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_CALC  = 8'b0010_0000,
        S_WB    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [1:0]     axis_reg, axis_next;
    logic [1:0]     dphase_reg, dphase_next;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        axis_next   = axis_reg;
        dphase_next = dphase_reg;
        ctl         = '0;
        ctl.axis    = axis_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.start  = 1'b1;
                    axis_next  = 2'd0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!sts.in_range)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.is_load)
                begin
                    ctl.load = 1'b1;
                    if (axis_reg == 2'(vtu_pkg::AXES - 1))
                        state_next = S_IDLE;
                    else
                        axis_next = axis_reg + 1'b1;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                ctl.rd        = 1'b1;
                ctl.div_start = 1'b1;
                dphase_next   = 2'd0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    if (dphase_reg == 2'd2)
                    begin
                        state_next = S_CALC;
                    end
                    else
                    begin
                        ctl.div_start = 1'b1;
                        dphase_next   = dphase_reg + 1'b1;
                    end
                end
            end
            S_CALC:
            begin
                ctl.calc   = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                ctl.wb = 1'b1;
                if (axis_reg == 2'(vtu_pkg::AXES - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            axis_reg   <= '0;
            dphase_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            axis_reg   <= axis_next;
            dphase_reg <= dphase_next;
        end
    end

    assign clr_addr = clr_reg;

endmodule
`default_nettype wire

FILE: hdl/vtu_dp.sv
// ----------------------------------------------------------------------------
// vtu_dp
// Datapath: particle stores, shared divider and per-axis arithmetic.
// The divider runs three times per axis: (|F|dt)/m, then r*dt/m, r*fr/m.
// ----------------------------------------------------------------------------
`default_nettype none
module vtu_dp #(
    parameter int PARTICLE_COUNT = vtu_pkg::PARTICLE_COUNT_DEF,
    parameter int DEPTH          = PARTICLE_COUNT * vtu_pkg::AXES
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  vtu_pkg::ctl_t                 ctl,
    output vtu_pkg::sts_t                 sts,
    input  wire logic [$clog2(DEPTH)-1:0] clr_addr,
    input  wire logic [1:0]               in_cmd,
    input  wire logic [9:0]               in_particle,
    input  wire logic [95:0]              in_value,
    input  wire logic [31:0]              in_mass,
    input  wire logic [2:0]               in_fix,
    input  wire logic [16:0]              time_step,
    input  wire logic [16:0]              force_reduction,
    output logic      [319:0]             result
);

    localparam int AW = $clog2(DEPTH);

    logic [1:0]   cmd_reg;
    logic [9:0]   part_reg;
    logic [95:0]  val_reg;
    logic [31:0]  mass_reg;
    logic [2:0]   fix_reg;
    logic [297:0] res_reg;

    logic [AW-1:0] addr;
    logic          vel_we, dsp_we, org_we;
    logic [31:0]   vel_wd, dsp_wd, org_wd;
    logic [31:0]   vel_rd, dsp_rd, org_rd;

    logic [31:0]   f_s, f_mag, v_mag;
    logic          fneg, vneg, free_axis;
    logic [1:0]    dphase_reg;
    logic [63:0]   div_num;
    logic          div_done;
    logic [63:0]   quot;
    logic [31:0]   rem;
    logic [47:0]   q1_reg;
    logic [31:0]   r1_reg;
    logic [47:0]   tq_reg, kq_reg;
    logic [48:0]   vdt_reg;
    logic [48:0]   vdt_prod;
    logic [2:0]    fix_bit;

    assign addr = AW'(32'(part_reg) * 32'(vtu_pkg::AXES) + 32'(ctl.axis));

    always_comb
    begin
        f_s       = val_reg[32*ctl.axis +: 32];
        fneg      = f_s[31];
        f_mag     = fneg ? (~f_s + 1'b1) : f_s;
        vneg      = vel_rd[31];
        v_mag     = vneg ? (~vel_rd + 1'b1) : vel_rd;
        fix_bit   = fix_reg >> ctl.axis;
        free_axis = !fix_bit[0];
        vdt_prod  = 49'(v_mag) * 49'(time_step);
    end

    always_comb
    begin
        priority if (ctl.rd)
            div_num = 64'(f_mag) * 64'(time_step);
        else if (dphase_reg == 2'd0)
            div_num = 64'(rem) * 64'(time_step);
        else
            div_num = 64'(r1_reg) * 64'(force_reduction);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dphase_reg <= '0;
        end
        else if (ctl.rd)
        begin
            dphase_reg <= '0;
        end
        else if (div_done)
        begin
            dphase_reg <= dphase_reg + 1'b1;
        end
    end

    vtu_div #(
        .NUM_W(64),
        .DEN_W(32)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(ctl.div_start),
        .num  (div_num),
        .den  ((mass_reg == '0) ? 32'd1 : mass_reg),
        .done (div_done),
        .quot (quot),
        .rem  (rem)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            unique case (dphase_reg)
                2'd0:
                begin
                    q1_reg <= quot[47:0];
                    r1_reg <= rem;
                end
                2'd1:    tq_reg <= quot[47:0];
                default: kq_reg <= quot[47:0];
            endcase
        end
    end

    // stage after the divider: finish floor(p*k/(d*2^17))
    logic [47:0] lo_t, lo_k;
    logic [65:0] sum_t, sum_k;
    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            lo_t     <= 48'(q1_reg[16:0]) * 48'(time_step) + tq_reg;
            lo_k     <= 48'(q1_reg[16:0]) * 48'(force_reduction) + kq_reg;
            sum_t    <= 66'(q1_reg[47:17]) * 66'(time_step);
            sum_k    <= 66'(q1_reg[47:17]) * 66'(force_reduction);
            vdt_reg  <= vdt_prod;
        end
    end

    logic [65:0] term_m, kick_m;
    logic signed [65:0] vdt_s, term_s, kick_s, d_s, v_new, disp_new, crd;
    logic [31:0] step, disp_w, vel_w, crd_w, disp_cur;

    always_comb
    begin
        term_m   = sum_t + 66'(lo_t[47:17]);
        kick_m   = sum_k + 66'(lo_k[47:17]);
        vdt_s    = vneg ? -$signed(66'(vdt_reg[48:16])) : $signed(66'(vdt_reg[48:16]));
        term_s   = fneg ? -$signed(term_m) : $signed(term_m);
        kick_s   = fneg ? -$signed(kick_m) : $signed(kick_m);
        d_s      = free_axis ? vdt_s + term_s : vdt_s;
        if (d_s > 66'sd2147483647)
            step = 32'h7fff_ffff;
        else if (d_s < -66'sd2147483648)
            step = 32'h8000_0000;
        else
            step = d_s[31:0];
        if (cmd_reg != vtu_pkg::CMD_PREDICT)
            step = '0;
        disp_new = 66'($signed(dsp_rd)) + 66'($signed(step));
        disp_w   = vtu_pkg::sat32(disp_new[33:0]);
        disp_cur = (cmd_reg == vtu_pkg::CMD_PREDICT) ? disp_w : dsp_rd;
        v_new    = 66'($signed(vel_rd)) + kick_s;
        if (!free_axis)
            vel_w = vel_rd;
        else if (v_new > 66'sd2147483647)
            vel_w = 32'h7fff_ffff;
        else if (v_new < -66'sd2147483648)
            vel_w = 32'h8000_0000;
        else
            vel_w = v_new[31:0];
        crd      = 66'($signed(org_rd)) + 66'($signed(disp_cur));
        crd_w    = vtu_pkg::sat32(crd[33:0]);
    end

    always_comb
    begin
        vel_we = 1'b0;
        dsp_we = 1'b0;
        org_we = 1'b0;
        vel_wd = '0;
        dsp_wd = '0;
        org_wd = '0;
        if (ctl.clear_wr)
        begin
            vel_we = 1'b1;
            dsp_we = 1'b1;
            org_we = 1'b1;
        end
        else if (ctl.load)
        begin
            if (cmd_reg == vtu_pkg::CMD_LOAD_POS)
            begin
                org_we = 1'b1;
                dsp_we = 1'b1;
                org_wd = f_s;
            end
            else
            begin
                vel_we = 1'b1;
                vel_wd = f_s;
            end
        end
        else if (ctl.wb)
        begin
            vel_we = 1'b1;
            vel_wd = vel_w;
            dsp_we = 1'b1;
            dsp_wd = disp_cur;
        end
    end

    logic [AW-1:0] waddr;
    assign waddr = ctl.clear_wr ? clr_addr : addr;

    vtu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vel (
        .clk(clk), .we(vel_we), .waddr(waddr), .wdata(vel_wd), .raddr(addr), .rdata(vel_rd));
    vtu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dsp (
        .clk(clk), .we(dsp_we), .waddr(waddr), .wdata(dsp_wd), .raddr(addr), .rdata(dsp_rd));
    vtu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_org (
        .clk(clk), .we(org_we), .waddr(waddr), .wdata(org_wd), .raddr(addr), .rdata(org_rd));

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg  <= in_cmd;
            part_reg <= in_particle;
            val_reg  <= in_value;
            mass_reg <= in_mass;
            fix_reg  <= in_fix;
        end
        if (ctl.start)
        begin
            res_reg[9:0] <= in_particle;
        end
        if (ctl.wb)
        begin
            res_reg[10 + 32*ctl.axis +: 32]  <= crd_w;
            res_reg[106 + 32*ctl.axis +: 32] <= vel_w;
            res_reg[202 + 32*ctl.axis +: 32] <= step;
        end
    end

    assign result = {22'd0, res_reg};

    assign sts.div_done = div_done;
    assign sts.is_load  = (cmd_reg == vtu_pkg::CMD_LOAD_POS) ||
                          (cmd_reg == vtu_pkg::CMD_LOAD_VEL);
    assign sts.in_range = (32'(part_reg) < 32'(PARTICLE_COUNT));

endmodule
`default_nettype wire

FILE: hdl/verlet_translation_update_top.sv
// ----------------------------------------------------------------------------
// verlet_translation_update_top
// Velocity Verlet translation update for particles in three axes, Q16.16.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes all PARTICLE_COUNT*3 store addresses;
// no item is taken meanwhile. Predict and correct run one shared 64-step
// restoring divider three times per axis; the result then waits in an
// output register while the next item is taken.
`default_nettype none
module verlet_translation_update_top #(
    parameter int PARTICLE_COUNT = vtu_pkg::PARTICLE_COUNT_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [143:0] s_tdata,   // cmd, particle, value_x, value_y, value_z, mass, fix_mask
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [303:0] m_tdata,   // particle_out, coord_x..z, vel_x..z, step_x..z
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [16:0]  cfg_data
);

    localparam int DEPTH = PARTICLE_COUNT * vtu_pkg::AXES;

    vtu_pkg::ctl_t     ctl;
    vtu_pkg::sts_t     sts;
    logic [$clog2(DEPTH)-1:0] clr_addr;
    logic [16:0]  ts_reg, fr_reg;
    logic [319:0] result;
    logic         out_valid_reg;
    logic [303:0] out_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= vtu_pkg::TIME_STEP_RST;
            fr_reg <= vtu_pkg::FORCE_REDUCTION_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vtu_pkg::REG_TIME_STEP:       ts_reg <= cfg_data;
                vtu_pkg::REG_FORCE_REDUCTION: fr_reg <= cfg_data;
                default:                      ts_reg <= ts_reg;
            endcase
        end
    end

    vtu_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .out_free(!out_valid_reg || m_tready),
        .sts     (sts),
        .ctl     (ctl),
        .clr_addr(clr_addr)
    );

    vtu_dp #(.PARTICLE_COUNT(PARTICLE_COUNT), .DEPTH(DEPTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .clr_addr       (clr_addr),
        .in_cmd         (s_tdata[1:0]),
        .in_particle    (s_tdata[11:2]),
        .in_value       (s_tdata[107:12]),
        .in_mass        (s_tdata[139:108]),
        .in_fix         (s_tdata[142:140]),
        .time_step      (ts_reg),
        .force_reduction(fr_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_data_reg <= result[303:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
